// ----- hdl/smpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet decoder package
// Shared types, register indexes and reset values for the packet decoder.
// ----------------------------------------------------------------------------
package smpd_pkg;

  // Widths fixed by the register and result formats.
  localparam int unsigned FrameBits       = 12;
  localparam int unsigned GainBits        = 4;
  localparam int unsigned DeltaBits       = 8;
  localparam int unsigned CfgIdxBits      = 3;
  localparam int unsigned DefaultCoordBits = 12;

  // Register reset values.
  localparam logic [GainBits-1:0]  GainReset   = 4'd1;
  localparam logic [FrameBits-1:0] LeftReset   = 12'd0;
  localparam logic [FrameBits-1:0] TopReset    = 12'd0;
  localparam logic [FrameBits-1:0] RightReset  = 12'd639;
  localparam logic [FrameBits-1:0] BottomReset = 12'd479;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ACCEL_GAIN   = 3'd0,
    CFG_FRAME_LEFT   = 3'd1,
    CFG_FRAME_TOP    = 3'd2,
    CFG_FRAME_RIGHT  = 3'd3,
    CFG_FRAME_BOTTOM = 3'd4
  } cfg_idx_e;

  // Position of the next byte within a packet, one-hot.
  typedef enum logic [2:0] {
    IDX_FIRST  = 3'b001,
    IDX_SECOND = 3'b010,
    IDX_THIRD  = 3'b100
  } byte_idx_e;

  // Decoded packet, valid as a whole when complete is set.
  typedef struct packed {
    logic                        complete;
    logic signed [DeltaBits-1:0] dx;
    logic signed [DeltaBits-1:0] dy;
    logic                        left;
    logic                        right;
  } pkt_t;

endpackage

// ----- hdl/smpd_assembler.sv -----
// ----------------------------------------------------------------------------
// Packet assembler
// Tracks the byte position within a three-byte packet and builds the deltas.
// ----------------------------------------------------------------------------
module smpd_assembler
  import smpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output pkt_t       pkt_o
);

  byte_idx_e  idx_q, idx_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic       sync;

  // A byte with bit 6 set always starts a new packet.
  assign sync = byte_i[6];

  always_comb begin
    idx_d    = idx_q;
    first_d  = first_q;
    second_d = second_q;
    pkt_o.complete = 1'b0;
    if (sync) begin
      first_d = byte_i;
      idx_d   = IDX_SECOND;
    end else begin
      unique case (idx_q)
        IDX_SECOND: begin
          second_d = byte_i;
          idx_d    = IDX_THIRD;
        end
        IDX_THIRD: begin
          pkt_o.complete = 1'b1;
          idx_d          = IDX_FIRST;
        end
        default: begin
          first_d = byte_i;
          idx_d   = IDX_SECOND;
        end
      endcase
    end
    pkt_o.dx    = {first_q[1:0], second_q[5:0]};
    pkt_o.dy    = {first_q[3:2], byte_i[5:0]};
    pkt_o.left  = first_q[5];
    pkt_o.right = first_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= IDX_FIRST;
      first_q  <= 8'd0;
      second_q <= 8'd0;
    end else if (fire_i) begin
      idx_q    <= idx_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

// ----- hdl/smpd_axis.sv -----
// ----------------------------------------------------------------------------
// Axis position unit
// Holds the pointer and accelerated positions of one axis and updates them.
// ----------------------------------------------------------------------------
module smpd_axis
  import smpd_pkg::*;
#(
  parameter int unsigned COORD_BITS = DefaultCoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic signed [DeltaBits-1:0] delta_i,
  input  logic [GainBits-1:0]         gain_i,
  input  logic [FrameBits-1:0]        lo_i,
  input  logic [FrameBits-1:0]        hi_i,
  output logic [COORD_BITS-1:0]       pointer_o,
  output logic [COORD_BITS-1:0]       previous_o,
  output logic [COORD_BITS-1:0]       scaled_o
);

  // Wide enough for any stored coordinate plus the largest scaled delta,
  // and for any frame bound as a positive signed value.
  localparam int unsigned BaseW = (COORD_BITS > FrameBits) ? COORD_BITS : FrameBits;
  localparam int unsigned SumW  = BaseW + 6;
  localparam int unsigned ProdW = DeltaBits + GainBits + 1;

  logic [COORD_BITS-1:0]   cursor_q, accel_q;
  logic signed [ProdW-1:0] prod;
  logic signed [SumW-1:0]  lo_s, hi_s, acc_sum, ptr_sum, acc_cl, ptr_cl;

  assign lo_s = {{(SumW-FrameBits){1'b0}}, lo_i};
  assign hi_s = {{(SumW-FrameBits){1'b0}}, hi_i};
  assign prod = ProdW'(delta_i) * ProdW'($signed({1'b0, gain_i}));

  assign acc_sum = $signed({{(SumW-COORD_BITS){1'b0}}, accel_q})
                 + {{(SumW-ProdW){prod[ProdW-1]}}, prod};
  assign ptr_sum = $signed({{(SumW-COORD_BITS){1'b0}}, cursor_q})
                 + {{(SumW-DeltaBits){delta_i[DeltaBits-1]}}, delta_i};

  // Low bound first, then high bound, so an inverted frame yields the high bound.
  always_comb begin
    acc_cl = acc_sum;
    if (acc_cl < 0) acc_cl = '0;
    if (acc_cl < lo_s) acc_cl = lo_s;
    if (acc_cl >= hi_s) acc_cl = hi_s;
    ptr_cl = ptr_sum;
    if (ptr_cl < lo_s) ptr_cl = lo_s;
    if (ptr_cl >= hi_s) ptr_cl = hi_s;
  end

  assign pointer_o  = ptr_cl[COORD_BITS-1:0];
  assign scaled_o   = acc_cl[COORD_BITS-1:0];
  assign previous_o = cursor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      accel_q  <= '0;
    end else if (upd_i) begin
      cursor_q <= pointer_o;
      accel_q  <= scaled_o;
    end
  end

endmodule

// ----- hdl/serial_mouse_packet_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// Serial mouse packet decoder
// Decodes three-byte serial mouse packets into deltas, buttons and positions.
// ----------------------------------------------------------------------------
// Usage:
// Bytes from the UART receiver enter on the input channel (in_valid_i,
// in_ready_o, rx_byte_i), one byte per transaction. Any byte with bit 6 set
// starts a new packet. The third byte of a packet produces one result
// transaction on the output channel (out_valid_o, out_ready_i and the result
// fields); the first and second bytes produce none.
// Each accepted byte sits in an input register while the decode and position
// update run, and the result of a third byte is then loaded into the output
// register. One byte is accepted every cycle; the only limit is the single
// output register.
// When the receiver stalls, the output register holds its result. First and
// second bytes keep flowing; a third byte waits in the input register until
// the output register is free, and in_ready_o stays low while it waits.
// Reset clears both positions to zero, restarts packet assembly and loads
// the register defaults (gain 1, frame 0..639 by 0..479). Configuration is
// written through cfg_we_i, cfg_idx_i and cfg_data_i while the block is idle.
// ----------------------------------------------------------------------------
module serial_mouse_packet_decoder_unit
  import smpd_pkg::*;
#(
  parameter int unsigned COORD_BITS = DefaultCoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic [CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [FrameBits-1:0]        cfg_data_i,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  // Output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DeltaBits-1:0] delta_x_o,
  output logic signed [DeltaBits-1:0] delta_y_o,
  output logic [FrameBits-1:0]        pointer_x_o,
  output logic [FrameBits-1:0]        pointer_y_o,
  output logic [FrameBits-1:0]        previous_x_o,
  output logic [FrameBits-1:0]        previous_y_o,
  output logic [FrameBits-1:0]        scaled_x_o,
  output logic [FrameBits-1:0]        scaled_y_o,
  output logic                        left_button_o,
  output logic                        right_button_o
);

  // Coordinates are reported in the frame width; narrower ones are
  // zero-extended, wider ones keep their low bits.
  localparam int unsigned ExtW = (COORD_BITS > FrameBits) ? COORD_BITS : FrameBits;

  // Configuration registers.
  logic [GainBits-1:0]  gain_q;
  logic [FrameBits-1:0] left_q, top_q, right_q, bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GainReset;
      left_q   <= LeftReset;
      top_q    <= TopReset;
      right_q  <= RightReset;
      bottom_q <= BottomReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEL_GAIN:   gain_q   <= cfg_data_i[GainBits-1:0];
        CFG_FRAME_LEFT:   left_q   <= cfg_data_i;
        CFG_FRAME_TOP:    top_q    <= cfg_data_i;
        CFG_FRAME_RIGHT:  right_q  <= cfg_data_i;
        CFG_FRAME_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_fire, stage_fire, out_load;
  pkt_t       pkt;

  // The staged byte moves on unless it completes a packet while the output
  // register still holds a result that the receiver has not taken.
  assign stage_fire = in_valid_q && (!pkt.complete || !out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || stage_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = stage_fire && pkt.complete;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (stage_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= rx_byte_i;
    end
  end

  smpd_assembler u_assembler (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (stage_fire),
    .byte_i (in_byte_q),
    .pkt_o  (pkt)
  );

  logic [COORD_BITS-1:0] ptr_x, ptr_y, prev_x, prev_y, scl_x, scl_y;

  smpd_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (out_load),
    .delta_i    (pkt.dx),
    .gain_i     (gain_q),
    .lo_i       (left_q),
    .hi_i       (right_q),
    .pointer_o  (ptr_x),
    .previous_o (prev_x),
    .scaled_o   (scl_x)
  );

  smpd_axis #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (out_load),
    .delta_i    (pkt.dy),
    .gain_i     (gain_q),
    .lo_i       (top_q),
    .hi_i       (bottom_q),
    .pointer_o  (ptr_y),
    .previous_o (prev_y),
    .scaled_o   (scl_y)
  );

  logic [ExtW-1:0] ptr_x_ext, ptr_y_ext, prev_x_ext, prev_y_ext, scl_x_ext, scl_y_ext;

  assign ptr_x_ext  = ExtW'(ptr_x);
  assign ptr_y_ext  = ExtW'(ptr_y);
  assign prev_x_ext = ExtW'(prev_x);
  assign prev_y_ext = ExtW'(prev_y);
  assign scl_x_ext  = ExtW'(scl_x);
  assign scl_y_ext  = ExtW'(scl_y);

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      delta_x_o      <= pkt.dx;
      delta_y_o      <= pkt.dy;
      pointer_x_o    <= ptr_x_ext[FrameBits-1:0];
      pointer_y_o    <= ptr_y_ext[FrameBits-1:0];
      previous_x_o   <= prev_x_ext[FrameBits-1:0];
      previous_y_o   <= prev_y_ext[FrameBits-1:0];
      scaled_x_o     <= scl_x_ext[FrameBits-1:0];
      scaled_y_o     <= scl_y_ext[FrameBits-1:0];
      left_button_o  <= pkt.left;
      right_button_o <= pkt.right;
    end
  end

  assign out_valid_o = out_valid_q;

  // A completed packet always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("completed packet did not produce a result");

  // A staged byte that cannot move on is kept unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !stage_fire |=> in_valid_q && $stable(in_byte_q))
    else $error("staged byte lost while stalled");

  // Clamped positions never pass the high bound of the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pointer_x_o <= right_q && scaled_x_o <= right_q)
    else $error("horizontal position beyond frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pointer_y_o <= bottom_q && scaled_y_o <= bottom_q)
    else $error("vertical position beyond frame");

endmodule
